// ----- hw/rtl/sha256_pkg.sv -----
package sha256_pkg;

	// block and digest geometry
	localparam int BLOCK_BYTES  = 64;
	localparam int ROUNDS       = 64;
	localparam int WINDOW_WORDS = 16;
	localparam int DIGEST_WORDS = 8;
	localparam int LEN_POS      = 56;
	localparam int BLOCK_BITS   = 512;

	// stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 40;

	// request kinds carried in s_tuser
	localparam logic REQ_BYTE   = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK = 8'h80;

	// round constants
	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		unique case (r)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// initial chaining values
	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] h;
		unique case (i)
			3'd0: h = 32'h6a09e667;
			3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372;
			3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f;
			3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			3'd7: h = 32'h5be0cd19;
			default: h = 32'h0;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ----- hw/rtl/sha256_stream_hasher.sv -----
// channel | dir | tdata                                   | tuser    | tlast
// s_*     | in  | [7:0] msg_byte                          | req_type | -
// m_*     | out | [31:0] digest_word, [34:32] word_index  | -        | digest_last
//
// a message byte is taken while idle; the byte that fills a block starts a compression
// (64 rounds on the single round unit, then one fold into the chaining words)
// a finish pushes padding and length one byte a cycle (9 to 72 bytes), pausing for
// each compression of a full block (one or two), then shows eight digest beats
// s_tready is high only while idle; digest beats wait as long as m_tready is low
// arst_n clears control state and loads the initial hash values
module sha256_stream_hasher
	import sha256_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] msg_byte
	input  logic [IN_TUSER_W-1:0]  s_tuser,   // [0] req_type
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
	output logic                   m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_ZERO,
		ST_LEN,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	state_t      state_q, ret_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  out_idx_q;
	logic [63:0] bit_total_q;
	logic [31:0] chain_q [DIGEST_WORDS];

	logic [23:0] asm_q;
	logic [31:0] win_q [WINDOW_WORDS];
	logic [31:0] v_q [8];
	logic [63:0] total_q;

	logic        push_en;
	logic [7:0]  push_byte;
	logic        fin_en;
	logic        wrap;
	logic        out_fire;
	logic [31:0] w_rnd;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] mj;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {5'b0, out_idx_q, chain_q[0]};
	assign m_tlast  = (out_idx_q == 3'(DIGEST_WORDS - 1));
	assign out_fire = m_tvalid && m_tready;

	// byte source: input stream or padding sequencer
	always_comb begin
		push_en   = 1'b0;
		push_byte = 8'h00;
		unique case (state_q)
			ST_IDLE: begin
				push_en   = s_tvalid && (s_tuser[0] == REQ_BYTE);
				push_byte = s_tdata[7:0];
			end
			ST_MARK: begin
				push_en   = 1'b1;
				push_byte = PAD_MARK;
			end
			ST_ZERO: begin
				push_en   = (fill_q != 6'(LEN_POS));
				push_byte = 8'h00;
			end
			ST_LEN: begin
				push_en   = 1'b1;
				push_byte = total_q[63:56];
			end
			default: begin
				push_en   = 1'b0;
				push_byte = 8'h00;
			end
		endcase
	end

	assign fin_en = (state_q == ST_IDLE) && s_tvalid && (s_tuser[0] == REQ_FINISH);
	assign wrap   = push_en && (&fill_q);

	// shared round unit: schedule word and the two temporaries
	always_comb begin
		if (rnd_q[5:4] == 2'b00) begin
			w_rnd = win_q[0];
		end else begin
			w_rnd = win_q[0] + small_sigma0(win_q[1]) + win_q[9] + small_sigma1(win_q[14]);
		end
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + big_sigma1(v_q[4]) + ch + round_k(rnd_q) + w_rnd;
		t2 = big_sigma0(v_q[0]) + mj;
	end

	// sequencer, counters and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			fill_q      <= '0;
			rnd_q       <= '0;
			out_idx_q   <= '0;
			bit_total_q <= '0;
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				chain_q[i] <= init_hash(3'(i));
			end
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (wrap) begin
						state_q     <= ST_ROUND;
						ret_q       <= ST_IDLE;
						rnd_q       <= '0;
						bit_total_q <= bit_total_q + 64'(BLOCK_BITS);
					end else if (fin_en) begin
						state_q <= ST_MARK;
					end
				end
				ST_MARK, ST_ZERO: begin
					if (wrap) begin
						state_q <= ST_ROUND;
						ret_q   <= ST_ZERO;
						rnd_q   <= '0;
					end else if (state_q == ST_MARK) begin
						state_q <= ST_ZERO;
					end else if (!push_en) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (wrap) begin
						state_q <= ST_ROUND;
						ret_q   <= ST_OUT;
						rnd_q   <= '0;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (&rnd_q) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < DIGEST_WORDS; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					state_q <= ret_q;
				end
				ST_OUT: begin
					if (out_fire) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (m_tlast) begin
							state_q     <= ST_IDLE;
							bit_total_q <= '0;
							for (int i = 0; i < DIGEST_WORDS; i++) begin
								chain_q[i] <= init_hash(3'(i));
							end
						end else begin
							for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
								chain_q[i] <= chain_q[i + 1];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: byte assembly, schedule window, working variables, length
	always_ff @(posedge clk) begin
		if (fin_en) begin
			total_q <= bit_total_q + 64'({fill_q, 3'b000});
		end else if (state_q == ST_LEN) begin
			total_q <= {total_q[55:0], 8'h00};
		end

		if (push_en) begin
			asm_q <= {asm_q[15:0], push_byte};
			if (&fill_q[1:0]) begin
				for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[WINDOW_WORDS - 1] <= {asm_q, push_byte};
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[WINDOW_WORDS - 1] <= w_rnd;
		end

		if (wrap) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

// ----- hw/rtl/sha256_stream_hasher_chk.sv -----
module sha256_stream_hasher_chk
	import sha256_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TUSER_W-1:0]  s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast
);

	// a stalled digest beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("digest beat changed while stalled");

	// no input is taken while a digest is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while digest pending");

	// last flag marks the final word index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[34:32] == 3'(DIGEST_WORDS - 1))
		else $error("last flag on wrong word");

	// digest words follow without a gap until the last
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside digest burst");

	// a finish beat closes the input side
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] == REQ_FINISH |=> !s_tready)
		else $error("ready right after finish");

endmodule

bind sha256_stream_hasher sha256_stream_hasher_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
